// File: hdl/boxavg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boxavg_pkg
// Shared types, constants and helpers for the box average decimator.
// ----------------------------------------------------------------------------
package boxavg_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SAMPLE_W     = 16;
    localparam int SUM_W        = SAMPLE_W + 2;
    localparam int OUT_CH_W     = 3;
    localparam int MODE_W       = 2;
    localparam int COUNT_W      = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 4;
    localparam int PHASE_W      = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_PASS    = 2'd0,
        MODE_HALVE   = 2'd1,
        MODE_QUARTER = 2'd2
    } decim_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DECIM_MODE    = 2'd0,
        REG_CHANNEL_COUNT = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COUNT_W-1:0] count;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [OUT_CH_W-1:0]        channel;
    } result_t;

    typedef struct packed {
        logic [CH_W-1:0]    pos;
        logic [PHASE_W-1:0] phase;
    } status_t;

    // Clamp the channel count into 1..MAX_CHANNELS.
    function automatic logic [COUNT_W-1:0] active_channels(input logic [COUNT_W-1:0] count);
        logic [COUNT_W-1:0] n;
        n = count;
        if (n == '0)
            n = COUNT_W'(1);
        if (32'(n) > MAX_CHANNELS)
            n = COUNT_W'(MAX_CHANNELS);
        return n;
    endfunction

    // Frame index of the last frame of a group.
    function automatic logic [PHASE_W-1:0] last_phase(input logic [MODE_W-1:0] mode);
        logic [PHASE_W-1:0] p;
        case (mode)
            MODE_HALVE:   p = PHASE_W'(1);
            MODE_QUARTER: p = PHASE_W'(3);
            default:      p = '0;
        endcase
        return p;
    endfunction

endpackage

// File: hdl/box_average_decimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_average_decimator
// Boxcar averaging decimator by 1, 2 or 4 for interleaved 16-bit audio.
// ----------------------------------------------------------------------------
// Input words arrive on in_valid/in_ready, one signed sample per word, with
// channels interleaved frame by frame. Results leave on out_valid/out_ready
// with the channel index of each sample.
// In pass-through mode every word gives one result; in halve or quarter mode
// a result per channel appears when the last frame of a group of 2 or 4 is
// taken, carrying the floor of the group average.
// Throughput is one word per clock while the output buffer has room or the
// held word gives no result. Each word is held in the input register, and its
// result is then written into the output buffer, which drives out_valid.
// A two-word output buffer lets the block keep taking words while a result
// waits; once both entries are full, the receiver stalls and a word with a
// result due sits in the input register, in_ready drops.
// Reset empties the pipeline, sets mode to pass-through and the channel count
// to two. Writing either configuration register restarts grouping at the next
// word; write only while idle. Partial groups wait until complete or restarted.
// ----------------------------------------------------------------------------
module box_average_decimator (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write_en,
    input  logic [boxavg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [boxavg_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [boxavg_pkg::SAMPLE_W-1:0] sample,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [boxavg_pkg::SAMPLE_W-1:0] out_sample,
    output logic [boxavg_pkg::OUT_CH_W-1:0]        out_channel
);
    import boxavg_pkg::*;

    cfg_t    cfg_reg;
    logic    cfg_clear;
    logic    buf_space;
    logic    push;
    result_t push_data;
    result_t out_data;
    status_t status;

    assign cfg_clear = cfg_write_en &&
                       (cfg_index == REG_DECIM_MODE || cfg_index == REG_CHANNEL_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode  <= MODE_PASS;
            cfg_reg.count <= COUNT_W'(2);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_DECIM_MODE:    cfg_reg.mode  <= cfg_data[MODE_W-1:0];
                REG_CHANNEL_COUNT: cfg_reg.count <= cfg_data[COUNT_W-1:0];
                default:           cfg_reg       <= cfg_reg;
            endcase
        end
    end

    boxavg_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cfg_clear (cfg_clear),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .buf_space (buf_space),
        .push      (push),
        .push_data (push_data),
        .status    (status)
    );

    boxavg_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .space     (buf_space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign out_sample  = out_data.sample;
    assign out_channel = out_data.channel;

    // Core never pushes into a full buffer.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> buf_space)
        else $error("result pushed into full output buffer");

    // Channel position stays inside the active channel count.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(status.pos) < 32'(active_channels(cfg_reg.count)))
        else $error("channel position out of range");

    // Frame phase never passes the last frame of the group.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.phase <= last_phase(cfg_reg.mode))
        else $error("frame phase out of range");

    // A word with no buffer room and a result due is held, not lost.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!buf_space && !in_ready) |=> !in_ready || $past(out_ready))
        else $error("input taken while stalled");

endmodule

// File: hdl/boxavg_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boxavg_core
// Input register, channel/frame sequencing, per-channel accumulators and
// the average computation feeding the output buffer.
// ----------------------------------------------------------------------------
module boxavg_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  boxavg_pkg::cfg_t                     cfg,
    input  logic                                 cfg_clear,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [boxavg_pkg::SAMPLE_W-1:0] sample,
    input  logic                                 buf_space,
    output logic                                 push,
    output boxavg_pkg::result_t                  push_data,
    output boxavg_pkg::status_t                  status
);
    import boxavg_pkg::*;

    logic                       s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic [CH_W-1:0]            pos_reg;
    logic [CH_W-1:0]            pos_next;
    logic [PHASE_W-1:0]         phase_reg;
    logic [PHASE_W-1:0]         phase_next;
    logic signed [SUM_W-1:0]    sums_reg [MAX_CHANNELS];

    logic [COUNT_W-1:0]         nch;
    logic [CH_W-1:0]            ch;
    logic [PHASE_W-1:0]         last;
    logic                       accumulate;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [SUM_W-1:0]    avg;
    logic                       produce;
    logic                       advance;
    logic [COUNT_W:0]           ch_inc;

    always_comb
    begin
        nch        = active_channels(cfg.count);
        ch         = (32'(pos_reg) >= 32'(nch)) ? '0 : pos_reg;
        last       = last_phase(cfg.mode);
        accumulate = (last != '0);
        sum_next   = (phase_reg == '0) ? SUM_W'(s1_sample_reg)
                                       : sums_reg[ch] + SUM_W'(s1_sample_reg);
        case (cfg.mode)
            MODE_HALVE:   avg = sum_next >>> 1;
            MODE_QUARTER: avg = sum_next >>> 2;
            default:      avg = SUM_W'(s1_sample_reg);
        endcase
        produce = !accumulate || (phase_reg == last);

        // Hold the word while the buffer is full; words that give no result still advance.
        advance  = s1_valid_reg && (buf_space || !produce);
        in_ready = !s1_valid_reg || advance;

        push              = advance && produce;
        push_data.sample  = avg[SAMPLE_W-1:0];
        push_data.channel = OUT_CH_W'(ch);

        ch_inc     = (COUNT_W + 1)'(ch) + (COUNT_W + 1)'(1);
        pos_next   = pos_reg;
        phase_next = phase_reg;
        if (advance)
        begin
            if (!accumulate)
                phase_next = '0;
            if (ch_inc >= (COUNT_W + 1)'(nch))
            begin
                pos_next = '0;
                if (accumulate)
                    phase_next = (phase_reg == last) ? '0 : phase_reg + PHASE_W'(1);
            end
            else
            begin
                pos_next = CH_W'(ch_inc);
            end
        end
        if (cfg_clear)
        begin
            pos_next   = '0;
            phase_next = '0;
        end

        status.pos   = pos_reg;
        status.phase = phase_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            pos_reg      <= '0;
            phase_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= (in_valid && in_ready) || (s1_valid_reg && !advance);
            pos_reg      <= pos_next;
            phase_reg    <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_sample_reg <= sample;
        if (advance && accumulate)
            sums_reg[ch] <= sum_next;
    end

endmodule

// File: hdl/boxavg_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boxavg_outbuf
// Two-word output buffer that decouples the result side from the input side.
// ----------------------------------------------------------------------------
module boxavg_outbuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  boxavg_pkg::result_t push_data,
    output logic                space,
    output logic                out_valid,
    input  logic                out_ready,
    output boxavg_pkg::result_t out_data
);
    import boxavg_pkg::*;

    result_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign space     = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the box average decimator.
// ----------------------------------------------------------------------------
// A short table of directed words and register writes runs first. It covers
// sample extremes, every mode including the unsupported one, clamped channel
// counts, a pending partial group and a write to an unused index. Random
// phases follow, each with random register writes, and feed whole groups with
// random content plus the odd broken trailing group. Every accepted word goes
// through a local model of the averager. Each result is matched in order
// against the queue of predicted samples. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module testbench;

    import boxavg_pkg::*;

    localparam int                       WORD_TARGET   = 1750;
    localparam int                       SETTLE_CYCLES = 6;
    localparam logic [CFG_IDX_W-1:0]     REG_UNUSED    = 2'd3;
    localparam logic [MODE_W-1:0]        MODE_UNSUPPORTED = 2'd3;

    typedef enum bit {ROW_WORD, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        logic [CFG_IDX_W-1:0]      reg_index;
        logic [CFG_DATA_W-1:0]     reg_value;
        logic signed [SAMPLE_W-1:0] value;
        bit                        known;
        logic signed [SAMPLE_W-1:0] known_sample;
        logic [OUT_CH_W-1:0]       known_channel;
    } plan_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_write_en;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        out_valid;
    logic                        out_ready;
    logic signed [SAMPLE_W-1:0]  out_sample;
    logic [OUT_CH_W-1:0]         out_channel;

    // literal expectation that travels with the word on the bus
    bit                          word_known;
    logic signed [SAMPLE_W-1:0]  word_known_sample;
    logic [OUT_CH_W-1:0]         word_known_channel;

    bit                          calm;
    int                          errors;
    int                          words_taken;
    int                          results_seen;
    int                          reg_writes;

    // model of the averager
    logic [MODE_W-1:0]           avg_mode;
    logic [COUNT_W-1:0]          avg_count;
    logic signed [SUM_W-1:0]     chan_sums [MAX_CHANNELS];
    int                          next_chan;
    int                          group_frame;
    result_t                     awaited_results [$];

    box_average_decimator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_sample   (out_sample),
        .out_channel  (out_channel)
    );

    always #5 clk = ~clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40)
            $display("%0t ns mismatch: %s", $time, msg);
    endtask

    function automatic void take_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
        if (idx == REG_DECIM_MODE)
            avg_mode = val[MODE_W-1:0];
        else if (idx == REG_CHANNEL_COUNT)
            avg_count = val[COUNT_W-1:0];
        else
            return;
        // grouping restarts at the next word
        next_chan   = 0;
        group_frame = 0;
    endfunction

    function automatic int live_channels();
        if (avg_count == '0)
            return 1;
        if (int'(avg_count) > MAX_CHANNELS)
            return MAX_CHANNELS;
        return int'(avg_count);
    endfunction

    function automatic int frames_per_group();
        case (avg_mode)
            MODE_HALVE:   return 2;
            MODE_QUARTER: return 4;
            default:      return 1;
        endcase
    endfunction

    // Advance the model by one word; returns 1 when a result falls out.
    function automatic bit box_average_step(input logic signed [SAMPLE_W-1:0] value,
                                            output result_t res);
        int                      nch;
        int                      grp;
        int                      ch;
        bit                      produced;
        logic signed [SUM_W-1:0] avg_sum;
        nch      = live_channels();
        grp      = frames_per_group();
        produced = 1'b0;
        res      = '0;
        if (next_chan >= nch)
            next_chan = 0;
        ch = next_chan;
        if (grp == 1) begin
            res.sample  = value;
            res.channel = OUT_CH_W'(ch);
            produced    = 1'b1;
            group_frame = 0;
        end
        else begin
            if (group_frame == 0)
                chan_sums[ch] = value;
            else
                chan_sums[ch] = chan_sums[ch] + value;
            if (group_frame == grp - 1) begin
                // arithmetic shift gives the floor of the average
                avg_sum     = chan_sums[ch] >>> ((grp == 2) ? 1 : 2);
                res.sample  = avg_sum[SAMPLE_W-1:0];
                res.channel = OUT_CH_W'(ch);
                produced    = 1'b1;
            end
        end
        next_chan = ch + 1;
        if (next_chan >= nch) begin
            next_chan = 0;
            if (grp > 1) begin
                group_frame++;
                if (group_frame >= grp)
                    group_frame = 0;
            end
        end
        return produced;
    endfunction

    always @(posedge clk)
    begin : track
        result_t predicted;
        result_t oldest;
        bit      produced;
        if (rst_n) begin
            if (cfg_write_en) begin
                take_reg_write(cfg_index, cfg_data);
                reg_writes++;
            end
            if (in_valid && in_ready) begin
                words_taken++;
                produced = box_average_step(sample, predicted);
                if (word_known)
                    awaited_results.push_back('{sample: word_known_sample,
                                                channel: word_known_channel});
                else if (produced)
                    awaited_results.push_back(predicted);
            end
            if (out_valid && out_ready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d ch %0d",
                                              out_sample, out_channel));
                end
                else begin
                    oldest = awaited_results.pop_front();
                    if (out_sample !== oldest.sample)
                        report_mismatch($sformatf("out_sample %0d, expected %0d",
                                                  out_sample, oldest.sample));
                    if (out_channel !== oldest.channel)
                        report_mismatch($sformatf("out_channel %0d, expected %0d",
                                                  out_channel, oldest.channel));
                end
            end
        end
    end

    // receiver: stall in bursts unless the phase runs calm
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(negedge clk);
        forever begin
            stall = calm ? 0 : idle_len();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(negedge clk);
        end
    end

    // Hold the word until taken; returns at the accepting edge.
    task automatic push_word(input logic signed [SAMPLE_W-1:0] value,
                             input bit known,
                             input logic signed [SAMPLE_W-1:0] known_sample,
                             input logic [OUT_CH_W-1:0] known_channel);
        int gap;
        gap = calm ? 0 : idle_len();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid           <= 1'b1;
        sample             <= value;
        word_known         <= known;
        word_known_sample  <= known_sample;
        word_known_channel <= known_channel;
        do @(posedge clk); while (!in_ready);
    endtask

    // Write only once the block has drained.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    function automatic plan_row_t word_row(input logic signed [SAMPLE_W-1:0] value);
        return '{ROW_WORD, '0, '0, value, 1'b0, '0, '0};
    endfunction

    function automatic plan_row_t known_row(input logic signed [SAMPLE_W-1:0] value,
                                            input logic signed [SAMPLE_W-1:0] res,
                                            input logic [OUT_CH_W-1:0] ch);
        return '{ROW_WORD, '0, '0, value, 1'b1, res, ch};
    endfunction

    function automatic plan_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] val);
        return '{ROW_WRITE, idx, val, '0, 1'b0, '0, '0};
    endfunction

    initial
    begin
        plan_row_t                  plan [$];
        int                         sent;
        int                         phase;
        int                         run;
        int                         frame_words;
        int                         r;
        int                         drain;
        logic [CFG_DATA_W-1:0]      count_val;
        logic signed [SAMPLE_W-1:0] v;

        rst_n              = 1'b0;
        cfg_write_en       = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        in_valid           = 1'b0;
        sample             = '0;
        word_known         = 1'b0;
        word_known_sample  = '0;
        word_known_channel = '0;
        calm               = 1'b0;
        errors             = 0;
        words_taken        = 0;
        results_seen       = 0;
        reg_writes         = 0;
        avg_mode           = MODE_PASS;
        avg_count          = COUNT_W'(2);
        next_chan          = 0;
        group_frame        = 0;
        foreach (chan_sums[i])
            chan_sums[i] = '0;

        // after reset: pass-through over two channels
        plan.push_back(known_row(16'sh7FFF, 16'sh7FFF, 3'd0));
        plan.push_back(known_row(16'sh8000, 16'sh8000, 3'd1));
        plan.push_back(known_row(16'sh0000, 16'sh0000, 3'd0));
        plan.push_back(known_row(16'shFFFF, 16'shFFFF, 3'd1));
        // pairs: full-scale positive, and a negative odd sum that must floor
        plan.push_back(write_row(REG_DECIM_MODE, CFG_DATA_W'(MODE_HALVE)));
        plan.push_back(word_row(16'sh7FFF));
        plan.push_back(word_row(16'shFFFF));
        plan.push_back(known_row(16'sh7FFF, 16'sh7FFF, 3'd0));
        plan.push_back(word_row(16'shFFFE));
        // quarter of full-scale negative on one channel
        plan.push_back(write_row(REG_DECIM_MODE, CFG_DATA_W'(MODE_QUARTER)));
        plan.push_back(write_row(REG_CHANNEL_COUNT, 4'd1));
        plan.push_back(word_row(16'sh8000));
        plan.push_back(word_row(16'sh8000));
        plan.push_back(word_row(16'sh8000));
        plan.push_back(known_row(16'sh8000, 16'sh8000, 3'd0));
        // zero channels act as one; leave a group pending, then drop it
        plan.push_back(write_row(REG_CHANNEL_COUNT, 4'd0));
        plan.push_back(word_row(16'sh0005));
        plan.push_back(write_row(REG_DECIM_MODE, CFG_DATA_W'(MODE_UNSUPPORTED)));
        plan.push_back(known_row(16'shFFF9, 16'shFFF9, 3'd0));
        // count above the maximum clamps; an unused index must not restart
        plan.push_back(write_row(REG_CHANNEL_COUNT, 4'd15));
        plan.push_back(word_row(16'sh0001));
        plan.push_back(word_row(16'sh0002));
        plan.push_back(word_row(16'sh0003));
        plan.push_back(write_row(REG_UNUSED, 4'hF));
        plan.push_back(word_row(16'sh0004));
        plan.push_back(word_row(16'sh0005));
        plan.push_back(word_row(16'sh0006));
        plan.push_back(word_row(16'sh0007));
        plan.push_back(word_row(16'sh0008));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        sent = 0;
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                write_reg(plan[i].reg_index, plan[i].reg_value);
            end
            else begin
                push_word(plan[i].value, plan[i].known,
                          plan[i].known_sample, plan[i].known_channel);
                sent++;
            end
        end

        phase = 0;
        while (sent < WORD_TARGET) begin
            calm = (phase % 4 == 3);
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_DECIM_MODE, CFG_DATA_W'($urandom_range(0, 15)));
            r = $urandom_range(0, 9);
            if (r == 0)
                count_val = 4'd0;
            else if (r == 1)
                count_val = 4'($urandom_range(9, 15));
            else
                count_val = 4'($urandom_range(1, 8));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_CHANNEL_COUNT, count_val);

            // whole groups, now and then a broken trailing group
            frame_words = live_channels() * frames_per_group();
            run = frame_words * $urandom_range(1, 6);
            if (frame_words == 1)
                run = run * 6;
            if ($urandom_range(0, 3) == 0)
                run += $urandom_range(1, frame_words);
            repeat (run) begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    v = 16'sh7FFF;
                else if (r == 1)
                    v = 16'sh8000;
                else if (r == 2)
                    v = 16'(int'($urandom_range(0, 8)) - 4);
                else
                    v = 16'($urandom);
                push_word(v, 1'b0, '0, '0);
                sent++;
            end
            phase++;
        end

        calm = 1'b0;
        @(negedge clk);
        in_valid <= 1'b0;
        drain = 0;
        while (awaited_results.size() != 0 && drain < 5000) begin
            @(negedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES * 4) @(negedge clk);
        if (awaited_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      awaited_results.size()));

        $display("run: %0d words in, %0d results out, %0d register writes, %0d phases",
                 words_taken, results_seen, reg_writes, phase);
        $display("run: pass, pairs, quarters and mode three over 1 to 8 channels");
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout");
        $display("testbench NOT OK");
        $finish;
    end

endmodule
